@@ rtl/core/utf8_uri_percent_encoder_macros.svh @@
// Assertion macros used by the percent encoder checker.
`ifndef UTF8_URI_PERCENT_ENCODER_MACROS_SVH
`define UTF8_URI_PERCENT_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define UUPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define UUPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/uupe_pkg.sv @@
// Shared types and constants of the URI percent encoder.
package uupe_pkg;

	// Width of the saturating encoded-length counter.
	localparam int CountWidth = 16;
	// Depth of the job queue between front and back.
	localparam int QueueDepth = 2;

	// What the back end does with one job.
	typedef enum logic [1:0] {
		JOB_PASS,
		JOB_ESC,
		JOB_ERR
	} job_kind_t;

	// One classified job: a plain byte, an escaped run of 1 to 4 bytes, or an error.
	typedef struct packed {
		job_kind_t        kind;
		logic [3:0][7:0]  bytes;
		logic [1:0]       last_idx;
		logic             fin;
	} job_t;

endpackage

@@ rtl/core/uupe_queue.sv @@
// Short job queue that decouples the classifier from the emitter.
module uupe_queue import uupe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	job_t            mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CntW'(QueueDepth));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Store the pushed word.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/uupe_front.sv @@
// Front end: accepts input bytes, checks UTF-8 and queues encode jobs.
module uupe_front import uupe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       is_final,
	output logic       push,
	output job_t       push_job,
	input  logic       full
);

	localparam logic [7:0] ChUpperA = 8'h41;
	localparam logic [7:0] ChUpperZ = 8'h5a;
	localparam logic [7:0] ChLowerA = 8'h61;
	localparam logic [7:0] ChLowerZ = 8'h7a;
	localparam logic [7:0] ChDigit0 = 8'h30;
	localparam logic [7:0] ChDigit9 = 8'h39;
	localparam logic [7:0] ChHyphen = 8'h2d;
	localparam logic [7:0] ChDot    = 8'h2e;
	localparam logic [7:0] ChUscore = 8'h5f;
	localparam logic [7:0] ChTilde  = 8'h7e;
	localparam logic [7:0] ChSlash  = 8'h2f;

	localparam logic [7:0] LeadMin  = 8'hc2;
	localparam logic [7:0] LeadMax  = 8'hf4;
	localparam logic [7:0] Lead3Min = 8'he0;
	localparam logic [7:0] Lead4Min = 8'hf0;
	localparam logic [7:0] LeadE0   = 8'he0;
	localparam logic [7:0] LeadED   = 8'hed;
	localparam logic [7:0] LeadF0   = 8'hf0;
	localparam logic [7:0] LeadF4   = 8'hf4;
	localparam logic [7:0] ContE0Lo = 8'ha0;
	localparam logic [7:0] ContEDHi = 8'h9f;
	localparam logic [7:0] ContF0Lo = 8'h90;
	localparam logic [7:0] ContF4Hi = 8'h8f;

	logic       esc_slash_q;
	logic [7:0] held_q [3];
	logic [1:0] held_cnt_q;
	logic [1:0] need_q;
	logic       skip_q;

	logic       acc;
	logic       passes;
	logic       is_lead;
	logic [1:0] lead_need;
	logic       cont_ok;
	logic       hold_lead;
	logic       hold_cont;
	logic       complete;
	logic       err;

	assign in_ready = !full;
	assign acc      = in_valid && in_ready;

	// Unreserved characters, and slash unless escaping is on.
	assign passes = ((in_byte >= ChUpperA) && (in_byte <= ChUpperZ))
		|| ((in_byte >= ChLowerA) && (in_byte <= ChLowerZ))
		|| ((in_byte >= ChDigit0) && (in_byte <= ChDigit9))
		|| (in_byte == ChHyphen) || (in_byte == ChDot)
		|| (in_byte == ChUscore) || (in_byte == ChTilde)
		|| ((in_byte == ChSlash) && !esc_slash_q);

	assign is_lead   = (in_byte >= LeadMin) && (in_byte <= LeadMax);
	assign lead_need = (in_byte < Lead3Min) ? 2'd1 : ((in_byte < Lead4Min) ? 2'd2 : 2'd3);

	// Check a continuation byte, with the narrowed range right after some leads.
	always_comb begin
		cont_ok = (in_byte[7:6] == 2'b10);
		if (cont_ok && (held_cnt_q == 2'd1)) begin
			unique case (held_q[0])
				LeadE0:  cont_ok = (in_byte >= ContE0Lo);
				LeadED:  cont_ok = (in_byte <= ContEDHi);
				LeadF0:  cont_ok = (in_byte >= ContF0Lo);
				LeadF4:  cont_ok = (in_byte <= ContF4Hi);
				default: cont_ok = 1'b1;
			endcase
		end
	end

	// Classify the byte and build the job word.
	always_comb begin
		push      = 1'b0;
		push_job  = '0;
		hold_lead = 1'b0;
		hold_cont = 1'b0;
		complete  = 1'b0;
		err       = 1'b0;
		if (!skip_q) begin
			if (need_q == 2'd0) begin
				if (!in_byte[7]) begin
					push              = 1'b1;
					push_job.kind     = passes ? JOB_PASS : JOB_ESC;
					push_job.bytes[0] = in_byte;
				end else if (is_lead) begin
					hold_lead = 1'b1;
					err       = is_final;
				end else begin
					err = 1'b1;
				end
			end else if (!cont_ok) begin
				err = 1'b1;
			end else if (need_q == 2'd1) begin
				push                       = 1'b1;
				complete                   = 1'b1;
				push_job.kind              = JOB_ESC;
				push_job.bytes[0]          = held_q[0];
				push_job.bytes[1]          = held_q[1];
				push_job.bytes[2]          = held_q[2];
				push_job.bytes[held_cnt_q] = in_byte;
				push_job.last_idx          = held_cnt_q;
			end else begin
				hold_cont = 1'b1;
				err       = is_final;
			end
		end
		if (err) begin
			push          = 1'b1;
			push_job      = '0;
			push_job.kind = JOB_ERR;
		end
		push_job.fin = is_final;
		push         = push && acc;
	end

	// Hold the bytes of an open sequence.
	always_ff @(posedge clk) begin
		if (acc && hold_lead) begin
			held_q[0] <= in_byte;
		end
		if (acc && hold_cont) begin
			held_q[held_cnt_q] <= in_byte;
		end
	end

	// Track the open sequence, the discard state and the slash register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_slash_q <= 1'b0;
			held_cnt_q  <= '0;
			need_q      <= '0;
			skip_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				esc_slash_q <= cfg_wr_data;
			end
			if (acc) begin
				if (hold_lead) begin
					held_cnt_q <= 2'd1;
					need_q     <= lead_need;
				end
				if (hold_cont) begin
					held_cnt_q <= held_cnt_q + 1'b1;
					need_q     <= need_q - 1'b1;
				end
				if (err || complete || is_final) begin
					held_cnt_q <= '0;
					need_q     <= '0;
				end
				if (skip_q) begin
					skip_q <= !is_final;
				end else begin
					skip_q <= err && !is_final;
				end
			end
		end
	end

endmodule

@@ rtl/core/uupe_back.sv @@
// Back end: expands queued jobs into encoded words, one per cycle unless out_ready stalls.
module uupe_back import uupe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_end,
	output logic        string_end,
	output logic        bad_utf8,
	output logic [15:0] encoded_count
);

	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [1:0] DigPct    = 2'd0;
	localparam logic [1:0] DigHi     = 2'd1;
	localparam logic [1:0] DigLo     = 2'd2;

	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  run_end_q;
	logic                  string_end_q;
	logic                  bad_utf8_q;
	logic [15:0]           count_q;
	logic [CountWidth-1:0] len_q;
	logic [1:0]            byte_idx_q;
	logic [1:0]            dig_idx_q;

	logic                  load;
	logic [7:0]            cur_src;
	logic [7:0]            cur_byte;
	logic                  cur_last;
	logic [CountWidth-1:0] len_inc;

	// Map a nibble to its uppercase hex character.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		ch = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
		return ch;
	endfunction

	assign load    = !empty && (!out_valid_q || out_ready);
	assign pop     = load && cur_last;
	assign cur_src = head.bytes[byte_idx_q];
	assign len_inc = (len_q == '1) ? len_q : len_q + 1'b1;

	// Pick the word for the current step of the head job.
	always_comb begin
		cur_byte = '0;
		cur_last = 1'b1;
		unique case (head.kind)
			JOB_PASS: begin
				cur_byte = head.bytes[0];
			end
			JOB_ESC: begin
				unique case (dig_idx_q)
					DigPct:  cur_byte = ChPercent;
					DigHi:   cur_byte = hex_char(cur_src[7:4]);
					default: cur_byte = hex_char(cur_src[3:0]);
				endcase
				cur_last = (dig_idx_q == DigLo) && (byte_idx_q == head.last_idx);
			end
			default: begin
				cur_byte = '0;
			end
		endcase
	end

	// Load the output register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= cur_byte;
			run_end_q    <= cur_last;
			string_end_q <= cur_last && head.fin;
			bad_utf8_q   <= (head.kind == JOB_ERR);
			count_q      <= (head.kind == JOB_ERR) ? 16'(len_q) : 16'(len_inc);
		end
	end

	// Advance the step counters and the running length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			byte_idx_q  <= '0;
			dig_idx_q   <= '0;
			len_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				if (cur_last) begin
					byte_idx_q <= '0;
					dig_idx_q  <= DigPct;
				end else if (dig_idx_q == DigLo) begin
					byte_idx_q <= byte_idx_q + 1'b1;
					dig_idx_q  <= DigPct;
				end else begin
					dig_idx_q <= dig_idx_q + 1'b1;
				end
				if ((head.kind == JOB_ERR) || (cur_last && head.fin)) begin
					len_q <= '0;
				end else begin
					len_q <= len_inc;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign run_end       = run_end_q;
	assign string_end    = string_end_q;
	assign bad_utf8      = bad_utf8_q;
	assign encoded_count = count_q;

endmodule

@@ rtl/core/utf8_uri_percent_encoder.sv @@
// Top level: UTF-8 to URI percent-encoding, front classifier, job queue and emitter.
// A completed job is written to the job queue and then loaded into the output register.
// Throughput: one input byte per cycle while the two-entry job queue has room; the emitter
// puts out one word per cycle when out_ready allows: one word per plain byte or error, three
// per escaped byte and per byte of a finished sequence; bytes held or discarded emit none.
// Reset: arst_n clears the slash register, sequence state, queue, counter and valid flags.
module utf8_uri_percent_encoder import uupe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        is_final,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_end,
	output logic        string_end,
	output logic        bad_utf8,
	output logic [15:0] encoded_count
);

	logic push;
	job_t push_job;
	logic full;
	logic pop;
	job_t head;
	logic empty;

	uupe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.is_final    (is_final),
		.push        (push),
		.push_job    (push_job),
		.full        (full)
	);

	uupe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	uupe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.run_end       (run_end),
		.string_end    (string_end),
		.bad_utf8      (bad_utf8),
		.encoded_count (encoded_count)
	);

endmodule

@@ rtl/core/uupe_checker.sv @@
// Port-level checker for the percent encoder, bound to the top level.
`include "utf8_uri_percent_encoder_macros.svh"

module uupe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        run_end,
	input logic        string_end,
	input logic        bad_utf8,
	input logic [15:0] encoded_count
);

	// A stalled word holds.
	`UUPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(encoded_count), "stalled output word changed")

	// An error word carries a zero byte and closes its run.
	`UUPE_ASSERT_NOW(a_err_word, out_valid && bad_utf8, (out_byte == 8'h00) && run_end, "error word malformed")

	// The end of a string is also the end of a run.
	`UUPE_ASSERT_NOW(a_str_end, out_valid && string_end, run_end, "string end without run end")

	// Every encoded word has been counted.
	`UUPE_ASSERT_NOW(a_count_nz, out_valid && !bad_utf8, encoded_count != 16'h0000, "encoded word with zero count")

endmodule

bind utf8_uri_percent_encoder uupe_checker u_chk (.*);
